[design/ptlru_pkg.sv]
// shared constants and types for the page translation block with lru replacement
// no dependencies
package ptlru_pkg;

    localparam int NUM_FRAMES_DEF = 128;
    localparam int PAGE_BYTES_DEF = 1024;
    localparam int VADDR_BITS_DEF = 32;

    localparam int VA_W = 32;
    localparam int PA_W = 17;
    localparam int EP_W = 22;
    localparam int AF_W = 8;

    localparam logic [AF_W-1:0] ACTIVE_FRAMES_RST = 8'd128;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_ACTIVE_FRAMES = 1'b0;

    localparam logic LIST_TOUCH  = 1'b0;
    localparam logic LIST_APPEND = 1'b1;

    typedef struct packed {
        logic valid;
        logic op;
    } t_list_cmd;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_scan_stat;

endpackage

[design/ptlru_scan.sv]
// page memory and sequential hit scan over the used frames
// depends on ptlru_pkg
module ptlru_scan #(
    parameter int NUM_FRAMES = ptlru_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_W     = 22
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [PAGE_W-1:0]                          i_page,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]            i_count,
    input  logic [((NUM_FRAMES>1)?$clog2(NUM_FRAMES):1)-1:0] i_head,
    input  logic                                       i_wr_en,
    input  logic [((NUM_FRAMES>1)?$clog2(NUM_FRAMES):1)-1:0] i_wr_addr,
    input  logic [PAGE_W-1:0]                          i_wr_page,
    output ptlru_pkg::t_scan_stat                      o_stat,
    output logic [((NUM_FRAMES>1)?$clog2(NUM_FRAMES):1)-1:0] o_hit_frame,
    output logic [PAGE_W-1:0]                          o_head_page
);

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

    logic [PAGE_W-1:0]  page_mem [NUM_FRAMES];

    logic               r_scanning;
    logic [CNT_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_count;
    logic               r_rd_vld;
    logic [FRAME_W-1:0] r_rd_addr;
    logic [PAGE_W-1:0]  r_rd;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_head;
    logic               r_hit;
    logic [FRAME_W-1:0] r_hit_frame;
    logic [PAGE_W-1:0]  r_head_page;
    logic [CNT_W-1:0]   n_addr;

    assign n_addr = r_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            page_mem[i_wr_addr] <= i_wr_page;
        end
        if (r_scanning) begin
            r_rd <= page_mem[r_addr[FRAME_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_rd_vld <= r_scanning;
            if (i_start) begin
                r_scanning <= (i_count != '0);
                r_hit      <= 1'b0;
            end else if (r_scanning && n_addr == r_count) begin
                r_scanning <= 1'b0;
            end
            if (r_rd_vld && r_rd == r_page) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr  <= '0;
            r_count <= i_count;
            r_page  <= i_page;
            r_head  <= i_head;
        end else if (r_scanning) begin
            r_addr <= n_addr;
        end
        if (r_scanning) begin
            r_rd_addr <= r_addr[FRAME_W-1:0];
        end
        if (r_rd_vld && r_rd == r_page) begin
            r_hit_frame <= r_rd_addr;
        end
        if (r_rd_vld && r_rd_addr == r_head) begin
            r_head_page <= r_rd;
        end
    end

    assign o_stat.busy = r_scanning || r_rd_vld;
    assign o_stat.hit  = r_hit;
    assign o_hit_frame = r_hit_frame;
    assign o_head_page = r_head_page;

endmodule

[design/ptlru_list.sv]
// lru order kept as a doubly linked list in two link memories, head is the victim
// depends on ptlru_pkg
module ptlru_list #(
    parameter int NUM_FRAMES = ptlru_pkg::NUM_FRAMES_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  ptlru_pkg::t_list_cmd                       i_cmd,
    input  logic [((NUM_FRAMES>1)?$clog2(NUM_FRAMES):1)-1:0] i_frame,
    output logic                                       o_busy,
    output logic [((NUM_FRAMES>1)?$clog2(NUM_FRAMES):1)-1:0] o_head
);

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    localparam logic [1:0] L_IDLE   = 2'd0;
    localparam logic [1:0] L_UNLINK = 2'd1;
    localparam logic [1:0] L_LINK   = 2'd2;

    logic [FRAME_W-1:0] prev_mem [NUM_FRAMES];
    logic [FRAME_W-1:0] next_mem [NUM_FRAMES];

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_head;
    logic [FRAME_W-1:0] r_tail;
    logic               r_empty;
    logic [FRAME_W-1:0] r_prev_q;
    logic [FRAME_W-1:0] r_next_q;

    logic               prev_we;
    logic [FRAME_W-1:0] prev_wa;
    logic [FRAME_W-1:0] prev_wd;
    logic               next_we;
    logic [FRAME_W-1:0] next_wa;
    logic [FRAME_W-1:0] next_wd;

    always_comb begin
        n_state = r_state;
        prev_we = 1'b0;
        prev_wa = r_frame;
        prev_wd = r_tail;
        next_we = 1'b0;
        next_wa = r_tail;
        next_wd = r_frame;
        unique case (r_state)
            L_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.op == ptlru_pkg::LIST_TOUCH) begin
                        if (i_frame != r_tail) begin
                            n_state = L_UNLINK;
                        end
                    end else if (!r_empty) begin
                        n_state = L_LINK;
                    end
                end
            end
            L_UNLINK: begin
                if (r_frame != r_head) begin
                    next_we = 1'b1;
                    next_wa = r_prev_q;
                    next_wd = r_next_q;
                    prev_we = 1'b1;
                    prev_wa = r_next_q;
                    prev_wd = r_prev_q;
                end
                n_state = L_LINK;
            end
            L_LINK: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (i_cmd.valid) begin
            r_prev_q <= prev_mem[i_frame];
            r_next_q <= next_mem[i_frame];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == L_IDLE && i_cmd.valid && i_cmd.op == ptlru_pkg::LIST_APPEND) begin
                r_empty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_cmd.valid) begin
            r_frame <= i_frame;
            if (i_cmd.op == ptlru_pkg::LIST_APPEND && r_empty) begin
                r_head <= i_frame;
                r_tail <= i_frame;
            end
        end
        if (r_state == L_UNLINK && r_frame == r_head) begin
            r_head <= r_next_q;
        end
        if (r_state == L_LINK) begin
            r_tail <= r_frame;
        end
    end

    assign o_busy = (r_state != L_IDLE);
    assign o_head = r_head;

endmodule

[design/page_translate_lru_replace_core.sv]
// top level: demand paging translation with lru page replacement
// depends on ptlru_pkg, ptlru_scan, ptlru_list
//
// One item is translated at a time. For each item the page memory is read one frame a cycle
// to look for the page and to fetch the page of the lru frame, then the linked lru list in
// the link memories is updated (read links, unlink, link at the tail).
// Used frames always form frames 0 to resident_count-1, so the state needs no clearing
// pass. A finished result sits in an output register while the next item is taken. The
// user must write active_frames at byte address 0 only while no item is in flight; the
// block itself does not enforce this.
module page_translate_lru_replace_core #(
    parameter int NUM_FRAMES = ptlru_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = ptlru_pkg::PAGE_BYTES_DEF,
    parameter int VADDR_BITS = ptlru_pkg::VADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ptlru_pkg::VA_W-1:0]    i_virtual_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ptlru_pkg::PA_W-1:0]    o_physical_address,
    output logic                          o_page_fault,
    output logic                          o_evicted,
    output logic [ptlru_pkg::EP_W-1:0]    o_evicted_page,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptlru_pkg::APB_AW-1:0]  paddr,
    input  logic [ptlru_pkg::APB_DW-1:0]  pwdata,
    output logic [ptlru_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = VADDR_BITS - OFF_W;
    localparam int CMP_W   = (CNT_W > ptlru_pkg::AF_W) ? CNT_W : ptlru_pkg::AF_W;
    localparam int PA_W    = ptlru_pkg::PA_W;
    localparam int EP_W    = ptlru_pkg::EP_W;
    localparam int DW      = ptlru_pkg::APB_DW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]                r_state;
    logic [ptlru_pkg::AF_W-1:0] r_active;
    logic [CNT_W-1:0]          r_count;
    logic [PAGE_W-1:0]         r_page;
    logic [OFF_W-1:0]          r_offset;
    logic [FRAME_W-1:0]        r_frame;
    logic                      r_fault;
    logic                      r_ev;
    logic [PAGE_W-1:0]         r_ev_page;

    logic                      r_out_valid;
    logic [PA_W-1:0]           r_pa;
    logic                      r_out_fault;
    logic                      r_out_ev;
    logic [EP_W-1:0]           r_out_ev_page;

    logic [VADDR_BITS-1:0]     va;
    logic                      in_accept;
    logic                      cfg_wr;
    logic [ptlru_pkg::AF_W-1:0] eff_active;
    logic                      free_avail;
    logic                      decide;
    logic                      finish;
    logic [FRAME_W-1:0]        n_frame;
    logic                      pg_wr;

    ptlru_pkg::t_scan_stat     scan_stat;
    logic [FRAME_W-1:0]        hit_frame;
    logic [PAGE_W-1:0]         head_page;
    ptlru_pkg::t_list_cmd      list_cmd;
    logic                      list_busy;
    logic [FRAME_W-1:0]        list_head;
    logic [FRAME_W+OFF_W-1:0]  pa_full;

    assign va         = VADDR_BITS'(i_virtual_address);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && paddr[ptlru_pkg::APB_AW-1:2] == ptlru_pkg::REG_ACTIVE_FRAMES;
    assign prdata = (paddr[ptlru_pkg::APB_AW-1:2] == ptlru_pkg::REG_ACTIVE_FRAMES)
                    ? DW'(r_active) : '0;

    assign eff_active = (r_active == '0) ? ptlru_pkg::AF_W'(1) : r_active;
    assign free_avail = (CMP_W'(r_count) < CMP_W'(eff_active))
                        && (r_count != CNT_W'(NUM_FRAMES));

    assign decide = (r_state == S_SCAN) && !scan_stat.busy;
    assign finish = (r_state == S_LIST) && !list_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        list_cmd.valid = decide;
        list_cmd.op    = ptlru_pkg::LIST_TOUCH;
        pg_wr          = 1'b0;
        n_frame        = list_head;
        if (scan_stat.hit) begin
            n_frame = hit_frame;
        end else if (free_avail) begin
            n_frame      = r_count[FRAME_W-1:0];
            list_cmd.op  = ptlru_pkg::LIST_APPEND;
            pg_wr        = decide;
        end else begin
            pg_wr = decide;
        end
    end

    ptlru_scan #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_W     (PAGE_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_page      (va[VADDR_BITS-1:OFF_W]),
        .i_count     (r_count),
        .i_head      (list_head),
        .i_wr_en     (pg_wr),
        .i_wr_addr   (n_frame),
        .i_wr_page   (r_page),
        .o_stat      (scan_stat),
        .o_hit_frame (hit_frame),
        .o_head_page (head_page)
    );

    ptlru_list #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (list_cmd),
        .i_frame (n_frame),
        .o_busy  (list_busy),
        .o_head  (list_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ptlru_pkg::ACTIVE_FRAMES_RST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_active <= pwdata[ptlru_pkg::AF_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (decide) begin
                        r_state <= S_LIST;
                        if (!scan_stat.hit && free_avail) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_LIST: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign pa_full = {r_frame, r_offset};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_page   <= va[VADDR_BITS-1:OFF_W];
            r_offset <= va[OFF_W-1:0];
        end
        if (decide) begin
            r_frame   <= n_frame;
            r_fault   <= !scan_stat.hit;
            r_ev      <= !scan_stat.hit && !free_avail;
            r_ev_page <= head_page;
        end
        if (finish) begin
            r_pa          <= PA_W'(pa_full);
            r_out_fault   <= r_fault;
            r_out_ev      <= r_ev;
            r_out_ev_page <= r_ev ? EP_W'(r_ev_page) : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_pa;
    assign o_page_fault       = r_out_fault;
    assign o_evicted          = r_out_ev;
    assign o_evicted_page     = r_out_ev_page;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_FRAMES))
        else $error("resident count beyond frame count");

    a_list_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        list_cmd.valid |-> !list_busy)
        else $error("list command while list update in progress");

    a_scan_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> !scan_stat.busy && !list_busy)
        else $error("item taken while previous item in flight");

    a_evict_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_page_fault |-> !o_evicted && o_evicted_page == '0)
        else $error("eviction reported on a hit");

endmodule

[tb/ptlru_checker.sv]
// checker for page_translate_lru_replace_core: follows the register port, predicts each
// translation with its own frame table and lru list, and compares every result item
// depends on ptlru_pkg
module ptlru_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [ptlru_pkg::VA_W-1:0]    i_virtual_address,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [ptlru_pkg::PA_W-1:0]    i_physical_address,
    input  logic                          i_page_fault,
    input  logic                          i_evicted,
    input  logic [ptlru_pkg::EP_W-1:0]    i_evicted_page,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ptlru_pkg::APB_AW-1:0]  i_paddr,
    input  logic [ptlru_pkg::APB_DW-1:0]  i_pwdata,
    input  logic [ptlru_pkg::APB_DW-1:0]  i_prdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptlru_pkg::*;

    localparam int FRAMES = NUM_FRAMES_DEF;
    localparam int OFF_W  = $clog2(PAGE_BYTES_DEF);
    localparam logic [APB_AW-1:0] AF_ADDR = APB_AW'({REG_ACTIVE_FRAMES, 2'b00});

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic            fault;
        logic            evict;
        logic [EP_W-1:0] victim;
    } t_xlate;

    logic [AF_W-1:0] af_reg;
    bit              frame_busy [FRAMES];
    logic [EP_W-1:0] frame_vpn [FRAMES];
    int              lru_q [$];
    t_xlate          xlate_q [$];
    int              fails = 0;

    function automatic t_xlate translate_va(input logic [VA_W-1:0] va);
        logic [EP_W-1:0] vpn;
        int              nact, frame, i;
        bit              hit, found;
        t_xlate          r;
        vpn   = va[VA_W-1:OFF_W];
        nact  = (af_reg == 0) ? 1 : ((af_reg > FRAMES) ? FRAMES : int'(af_reg));
        r     = '0;
        frame = 0;
        hit   = 1'b0;
        found = 1'b0;
        // lookup over every used frame, active or not
        for (i = 0; i < lru_q.size(); i++) begin
            if (frame_vpn[lru_q[i]] == vpn) begin
                frame = lru_q[i];
                hit   = 1'b1;
                lru_q.delete(i);
                lru_q.insert(lru_q.size(), frame);
                break;
            end
        end
        if (!hit) begin
            r.fault = 1'b1;
            for (i = 0; i < nact; i++) begin
                if (!frame_busy[i]) begin
                    frame = i;
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                frame    = lru_q[0];
                lru_q.delete(0);
                r.evict  = 1'b1;
                r.victim = frame_vpn[frame];
            end
            frame_busy[frame] = 1'b1;
            frame_vpn[frame]  = vpn;
            lru_q.insert(lru_q.size(), frame);
        end
        r.pa = PA_W'(frame * PAGE_BYTES_DEF + int'(va[OFF_W-1:0]));
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_xlate want;
        t_xlate pred;
        int     f;
        if (!i_rst_n) begin
            af_reg = ACTIVE_FRAMES_RST;
            for (f = 0; f < FRAMES; f++) frame_busy[f] = 1'b0;
            lru_q.delete();
            xlate_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (xlate_q.size() == 0) begin
                    $display({"%0t ns: unexpected item, expected none, ",
                              "got pa=%0h fault=%0b evict=%0b victim=%0h"},
                             $time, i_physical_address, i_page_fault, i_evicted,
                             i_evicted_page);
                    fails++;
                end else begin
                    want = xlate_q[0];
                    xlate_q.delete(0);
                    check_field("physical_address", 32'(want.pa), 32'(i_physical_address));
                    check_field("page_fault", 32'(want.fault), 32'(i_page_fault));
                    check_field("evicted", 32'(want.evict), 32'(i_evicted));
                    check_field("evicted_page", 32'(want.victim), 32'(i_evicted_page));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pred = translate_va(i_virtual_address);
                xlate_q.insert(xlate_q.size(), pred);
            end
            if (i_psel && i_penable && i_pready && i_paddr == AF_ADDR) begin
                if (i_pwrite)
                    af_reg = i_pwdata[AF_W-1:0];
                else
                    check_field("active_frames readback", APB_DW'(af_reg), i_prdata);
            end
        end
        o_pending    <= xlate_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/tb.sv]
// testbench top for page_translate_lru_replace_core: drives translations and register
// writes with random idling on both sides and gives the verdict
// depends on ptlru_pkg, page_translate_lru_replace_core and ptlru_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptlru_pkg::*;

    localparam int FRAMES      = NUM_FRAMES_DEF;
    localparam int OFF_W       = VA_W - EP_W;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam logic [APB_AW-1:0] AF_ADDR     = APB_AW'({REG_ACTIVE_FRAMES, 2'b00});
    localparam logic [APB_AW-1:0] NO_REG_ADDR = AF_ADDR + APB_AW'(4);

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [VA_W-1:0]   i_virtual_address = '0;
    logic              i_out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic              o_in_stall, o_out_valid, o_page_fault, o_evicted, pready;
    logic [PA_W-1:0]   o_physical_address;
    logic [EP_W-1:0]   o_evicted_page;
    logic [APB_DW-1:0] prdata;
    int                fail_count, pending;
    int                hold_asked = 0;
    int                hold_served = 0;
    bit                tx_idle = 1'b1;

    always #4 i_clk = ~i_clk;

    page_translate_lru_replace_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_virtual_address  (i_virtual_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_physical_address (o_physical_address),
        .o_page_fault       (o_page_fault),
        .o_evicted          (o_evicted),
        .o_evicted_page     (o_evicted_page),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    ptlru_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_virtual_address  (i_virtual_address),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_physical_address (o_physical_address),
        .i_page_fault       (o_page_fault),
        .i_evicted          (o_evicted),
        .i_evicted_page     (o_evicted_page),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_prdata           (prdata),
        .i_pready           (pready),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side stalls
    initial begin : rx_side
        int n, r;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                i_out_stall <= 1'b1;
                n = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 8);
                end else if (r < 88) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 4);
                end else if (r < 95) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(10, 60);
                end else begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(50, 300);
                end
            end
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [VA_W-1:0] va);
        int r, gap;
        i_in_valid <= 1'b1;
        i_virtual_address <= va;
        do @(posedge i_clk); while (o_in_stall);
        gap = 0;
        if (tx_idle) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                gap = $urandom_range(1, 3);
            else if (r < 42)
                gap = $urandom_range(4, 20);
            else if (r < 45)
                gap = $urandom_range(30, 100);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frames(input logic [AF_W-1:0] af);
        apb_xfer(1'b1, AF_ADDR, APB_DW'(af));
        apb_xfer(1'b0, AF_ADDR, '0);
    endtask

    function automatic logic [VA_W-1:0] pick_addr(input logic [EP_W-1:0] base, input int span);
        logic [EP_W-1:0] vpn;
        if ($urandom_range(0, 99) < 12) return $urandom;
        vpn = base + EP_W'($urandom_range(0, span - 1));
        return {vpn, OFF_W'($urandom)};
    endfunction

    initial begin : stim
        int              p, k, eff, span;
        logic [AF_W-1:0] af;
        logic [EP_W-1:0] base;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value readback, then fill a few frames with extreme addresses
        apb_xfer(1'b0, AF_ADDR, '0);
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'h0000_03FF);
        send_item(32'hFFFF_FC00);
        send_item(32'h0000_0400);
        send_item(32'h5555_5555);
        send_item(32'hAAAA_AAAA);
        send_item(32'h0000_0000);
        drain();

        // shrink below the used frames: hits above the active count, lru eviction
        set_frames(8'd2);
        send_item(32'h0000_07FF);
        send_item(32'h1234_5678);
        send_item(32'hFFFF_FFFF);
        send_item(32'hAAAA_AAAA);
        drain();

        // zero acts as one
        set_frames(8'd0);
        send_item(32'hDEAD_BEEF);
        send_item(32'h0000_0000);
        drain();

        // write to an address with no register, then above the frame count
        apb_xfer(1'b1, NO_REG_ADDR, '1);
        apb_xfer(1'b0, AF_ADDR, '0);
        set_frames(8'd255);
        send_item(32'h8000_0000);
        send_item(32'h7FFF_FFFF);
        drain();
        set_frames(8'd129);
        send_item(32'h0001_0000);
        send_item(32'h0000_0400);
        drain();

        base = EP_W'($urandom);
        for (p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: af = 8'd1;
                1: af = 8'd128;
                2: af = 8'd0;
                3: af = 8'd4;
                4: af = 8'd255;
                5: af = 8'd2;
                default: af = AF_W'($urandom_range(0, 255));
            endcase
            set_frames(af);
            eff = (af == 0) ? 1 : ((af > FRAMES) ? FRAMES : int'(af));
            if ($urandom_range(0, 1) != 0) base = EP_W'($urandom);
            span = eff + $urandom_range(0, eff / 4 + 3);
            if ($urandom_range(0, 3) == 0) span = eff / 2 + 1;
            tx_idle = ($urandom_range(0, 3) != 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 30) hold_asked <= hold_asked + 1;
                if (p == 3 && k == 75) drain();
                send_item(pick_addr(base, span));
            end
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
design/ptlru_pkg.sv
design/ptlru_scan.sv
design/ptlru_list.sv
design/page_translate_lru_replace_core.sv
tb/ptlru_checker.sv
tb/tb.sv
